>>> design/cfpv_pkg.sv
// ----------------------------------------------------------------------------
// cfpv_pkg
// Shared types, widths and codes for the camera frustum point visibility block.
// ----------------------------------------------------------------------------
package cfpv_pkg;

  // coordinate width of points and translation, Q.16 two's complement
  localparam int CW   = 32;
  localparam int FW   = 16;           // fraction bits of coordinates
  localparam int RW   = 18;           // rotation entry, signed Q2.16
  localparam int NW   = 16;           // normal component, signed Q2.14
  localparam int KW   = 16;           // intrinsic field, unsigned Q12.4

  // rotation products and sums
  localparam int PRW  = RW + CW;
  localparam int SUMW = PRW + 2;
  // camera point and offset width
  localparam int PW   = SUMW - FW + 1;

  // projection window products
  localparam int F10W = KW + 5;       // 10*f as a signed value
  localparam int L16W = KW + 9;       // 160*limit as a signed value
  localparam int CMPW = L16W + PW + 1;

  // distance squares, split into partial products
  localparam int SL   = PW / 2;
  localparam int SH   = PW - SL;
  localparam int SQW  = 2 * PW;
  localparam int SW   = SQW + 2;

  // dot product with the normal and its square
  localparam int DW   = PW + NW + 2;
  localparam int DL   = (DW - 1) / 2;
  localparam int DH   = DW - 1 - DL;
  localparam int D2W  = 2 * (DW - 1);
  localparam int QW   = ((D2W > SW + 26) ? D2W : SW + 26) + 1;

  // register indexes of the configuration port
  localparam logic [2:0] CFG_ROT_ROW0   = 3'd0;
  localparam logic [2:0] CFG_ROT_ROW1   = 3'd1;
  localparam logic [2:0] CFG_ROT_ROW2   = 3'd2;
  localparam logic [2:0] CFG_TRANS_X    = 3'd3;
  localparam logic [2:0] CFG_TRANS_Y    = 3'd4;
  localparam logic [2:0] CFG_TRANS_Z    = 3'd5;
  localparam logic [2:0] CFG_INTRINSICS = 3'd6;
  localparam logic [2:0] CFG_IMAGE_SIZE = 3'd7;

  // reject reasons
  typedef enum logic [2:0] {
    RC_SEEN      = 3'd0,
    RC_BEHIND    = 3'd1,
    RC_OFF_IMAGE = 3'd2,
    RC_DIST      = 3'd3,
    RC_ANGLE     = 3'd4
  } reject_code_e;

  // signed rotation entry c of a packed row
  function automatic logic signed [RW-1:0] rot_entry(input logic [3*RW-1:0] row,
                                                     input int c);
    rot_entry = $signed(row[RW*c +: RW]);
  endfunction

endpackage

>>> design/camera_frustum_point_visibility.sv
// ----------------------------------------------------------------------------
// camera_frustum_point_visibility
// Frustum, distance and viewing angle test of one map point per cycle.
// ----------------------------------------------------------------------------
// The block takes one world point per cycle and passes it through six register
// stages (rotation products, rotation sums, window and square products, window
// compares, distance compare with the dot product square, angle compare) that
// each hold one point, so a new point enters in every cycle as long as results
// are taken. A stalled output holds the pipeline only up to the first empty
// stage. Configuration must be written only while no point is in flight; the
// block itself does not enforce this.
module camera_frustum_point_visibility
  import cfpv_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [63:0]          cfg_data_i,
  // point input
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic signed [31:0]   point_x_i,
  input  logic signed [31:0]   point_y_i,
  input  logic signed [31:0]   point_z_i,
  input  logic [31:0]          min_dist_i,
  input  logic [31:0]          max_dist_i,
  input  logic signed [15:0]   normal_x_i,
  input  logic signed [15:0]   normal_y_i,
  input  logic signed [15:0]   normal_z_i,
  // verdict output
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 visible_o,
  output logic [2:0]           reject_code_o
);

  // configuration registers
  logic [3*RW-1:0]     rot_q [3];
  logic signed [CW-1:0] trans_q [3];
  logic [63:0]         intr_q;
  logic [31:0]         size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q[0]   <= 54'd65536;
      rot_q[1]   <= 54'd4294967296;
      rot_q[2]   <= 54'd17179869184;
      trans_q[0] <= '0;
      trans_q[1] <= '0;
      trans_q[2] <= '0;
      intr_q     <= '0;
      size_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROT_ROW0:   rot_q[0]   <= cfg_data_i[3*RW-1:0];
        CFG_ROT_ROW1:   rot_q[1]   <= cfg_data_i[3*RW-1:0];
        CFG_ROT_ROW2:   rot_q[2]   <= cfg_data_i[3*RW-1:0];
        CFG_TRANS_X:    trans_q[0] <= $signed(cfg_data_i[CW-1:0]);
        CFG_TRANS_Y:    trans_q[1] <= $signed(cfg_data_i[CW-1:0]);
        CFG_TRANS_Z:    trans_q[2] <= $signed(cfg_data_i[CW-1:0]);
        CFG_INTRINSICS: intr_q     <= cfg_data_i;
        CFG_IMAGE_SIZE: size_q     <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // stage valid bits and enables, a stage loads when it is empty or drains
  logic [6:1] v_q;
  logic [6:1] en;

  always_comb begin
    en[6] = !v_q[6] || !out_stall_i;
    for (int k = 5; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) v_q[1] <= in_valid_i;
      for (int k = 2; k <= 6; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // stage 1: rotation products of point and translation
  logic signed [PRW-1:0] rp_q [3][3];
  logic signed [PRW-1:0] rt_q [3][3];
  logic signed [CW-1:0]  p1_q [3];
  logic signed [NW-1:0]  n1_q [3];
  logic [31:0]           mn1_q, mx1_q;
  logic signed [CW-1:0]  pin [3];

  assign pin[0] = point_x_i;
  assign pin[1] = point_y_i;
  assign pin[2] = point_z_i;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          rp_q[i][j] <= rot_entry(rot_q[i], j) * pin[j];
          rt_q[i][j] <= rot_entry(rot_q[j], i) * trans_q[j];
        end
        p1_q[i] <= pin[i];
      end
      n1_q[0] <= normal_x_i;
      n1_q[1] <= normal_y_i;
      n1_q[2] <= normal_z_i;
      mn1_q   <= min_dist_i;
      mx1_q   <= max_dist_i;
    end
  end

  // stage 2: camera point and offset from the camera centre
  logic signed [PW-1:0] pc2_q [3];
  logic signed [PW-1:0] po2_q [3];
  logic signed [NW-1:0] n2_q [3];
  logic [31:0]          mn2_q, mx2_q;
  logic signed [SUMW-1:0] asum [3];
  logic signed [SUMW-1:0] bsum [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      asum[i] = SUMW'(rp_q[i][0]) + SUMW'(rp_q[i][1]) + SUMW'(rp_q[i][2]);
      bsum[i] = SUMW'(rt_q[i][0]) + SUMW'(rt_q[i][1]) + SUMW'(rt_q[i][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        pc2_q[i] <= PW'(asum[i] >>> FW) + PW'(trans_q[i]);
        po2_q[i] <= PW'(p1_q[i]) + PW'(bsum[i] >>> FW);
        n2_q[i]  <= n1_q[i];
      end
      mn2_q <= mn1_q;
      mx2_q <= mx1_q;
    end
  end

  // stage 3: window products, partial squares, dot product terms
  logic signed [F10W+PW-1:0] fxx_q, cxz_q, fyy_q, cyz_q;
  logic signed [11+PW-1:0]   z592_q;
  logic signed [L16W+PW-1:0] wz_q, hz_q;
  logic [2*SH-1:0]           shh_q [3];
  logic [SH+SL-1:0]          shl_q [3];
  logic [2*SL-1:0]           sll_q [3];
  logic signed [PW+NW-1:0]   pn_q [3];
  logic [63:0]               mnsq3_q, mxsq3_q;
  logic                      zpos3_q;

  logic signed [F10W-1:0] fx10, fy10, cx10, cy10;
  logic signed [L16W-1:0] w160, h160;
  logic [PW-1:0]          mag [3];

  always_comb begin
    fx10 = $signed({1'b0, (F10W-1)'(intr_q[15:0])  * (F10W-1)'(10)});
    fy10 = $signed({1'b0, (F10W-1)'(intr_q[31:16]) * (F10W-1)'(10)});
    cx10 = $signed({1'b0, (F10W-1)'(intr_q[47:32]) * (F10W-1)'(10)});
    cy10 = $signed({1'b0, (F10W-1)'(intr_q[63:48]) * (F10W-1)'(10)});
    w160 = $signed({1'b0, (L16W-1)'(size_q[15:0])  * (L16W-1)'(160)});
    h160 = $signed({1'b0, (L16W-1)'(size_q[31:16]) * (L16W-1)'(160)});
    for (int i = 0; i < 3; i++) begin
      mag[i] = po2_q[i][PW-1] ? $unsigned(~po2_q[i]) + PW'(1) : $unsigned(po2_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      fxx_q   <= fx10 * pc2_q[0];
      cxz_q   <= cx10 * pc2_q[2];
      fyy_q   <= fy10 * pc2_q[1];
      cyz_q   <= cy10 * pc2_q[2];
      z592_q  <= 11'sd592 * pc2_q[2];
      wz_q    <= w160 * pc2_q[2];
      hz_q    <= h160 * pc2_q[2];
      zpos3_q <= !pc2_q[2][PW-1] && (pc2_q[2] != '0);
      for (int i = 0; i < 3; i++) begin
        shh_q[i] <= mag[i][PW-1:SL] * mag[i][PW-1:SL];
        shl_q[i] <= mag[i][PW-1:SL] * mag[i][SL-1:0];
        sll_q[i] <= mag[i][SL-1:0] * mag[i][SL-1:0];
        pn_q[i]  <= po2_q[i] * n2_q[i];
      end
      mnsq3_q <= 64'(mn2_q) * 64'(mn2_q);
      mxsq3_q <= 64'(mx2_q) * 64'(mx2_q);
    end
  end

  // stage 4: projection window compares, squares, dot product
  logic                 zpos4_q, offimg4_q;
  logic [SQW-1:0]       sq4_q [3];
  logic signed [DW-1:0] d4_q;
  logic [63:0]          mnsq4_q, mxsq4_q;

  logic signed [CMPW-1:0] n10x, n10y;
  logic                   winx, winy;
  logic [SQW-1:0]         sq [3];

  always_comb begin
    n10x = CMPW'(fxx_q) + CMPW'(cxz_q);
    n10y = CMPW'(fyy_q) + CMPW'(cyz_q);
    winx = (n10x >= CMPW'(z592_q)) && (CMPW'(wz_q) >= n10x);
    winy = (n10y >= CMPW'(z592_q)) && (CMPW'(hz_q) >= n10y);
    for (int i = 0; i < 3; i++) begin
      sq[i] = (SQW'(shh_q[i]) << (2 * SL)) + (SQW'(shl_q[i]) << (SL + 1))
            + SQW'(sll_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      zpos4_q   <= zpos3_q;
      offimg4_q <= !(winx && winy);
      for (int i = 0; i < 3; i++) sq4_q[i] <= sq[i];
      d4_q    <= DW'(pn_q[0]) + DW'(pn_q[1]) + DW'(pn_q[2]);
      mnsq4_q <= mnsq3_q;
      mxsq4_q <= mxsq3_q;
    end
  end

  // stage 5: squared length, distance window, dot product square terms
  logic            zpos5_q, offimg5_q, distok5_q, dneg5_q;
  logic [SW-1:0]   s5_q;
  logic [2*DH-1:0] dhh_q;
  logic [DH+DL-1:0] dhl_q;
  logic [2*DL-1:0] dll_q;

  logic [SW-1:0]   ssum;
  logic [DW-2:0]   dmag;

  always_comb begin
    ssum = SW'(sq4_q[0]) + SW'(sq4_q[1]) + SW'(sq4_q[2]);
    dmag = d4_q[DW-2:0];
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      zpos5_q   <= zpos4_q;
      offimg5_q <= offimg4_q;
      distok5_q <= (ssum >= SW'(mnsq4_q)) && (SW'(mxsq4_q) >= ssum);
      dneg5_q   <= d4_q[DW-1];
      s5_q      <= ssum;
      dhh_q     <= dmag[DW-2:DL] * dmag[DW-2:DL];
      dhl_q     <= dmag[DW-2:DL] * dmag[DL-1:0];
      dll_q     <= dmag[DL-1:0] * dmag[DL-1:0];
    end
  end

  // stage 6: angle compare and verdict
  logic [QW-1:0] d2, s26;
  logic          angok;
  reject_code_e  code;
  logic          visible_q;
  reject_code_e  code_q;

  always_comb begin
    d2    = (QW'(dhh_q) << (2 * DL)) + (QW'(dhl_q) << (DL + 1)) + QW'(dll_q);
    s26   = QW'(s5_q) << 26;
    angok = !dneg5_q && (d2 >= s26);
    if (!zpos5_q) begin
      code = RC_BEHIND;
    end else if (offimg5_q) begin
      code = RC_OFF_IMAGE;
    end else if (!distok5_q) begin
      code = RC_DIST;
    end else if (!angok) begin
      code = RC_ANGLE;
    end else begin
      code = RC_SEEN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      visible_q <= (code == RC_SEEN);
      code_q    <= code;
    end
  end

  assign out_valid_o   = v_q[6];
  assign visible_o     = visible_q;
  assign reject_code_o = code_q;

endmodule

>>> design/cfpv_checker.sv
// ----------------------------------------------------------------------------
// cfpv_checker
// Port level checks of the visibility block, attached by bind.
// ----------------------------------------------------------------------------
module cfpv_checker
  import cfpv_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       visible_o,
  input logic [2:0] reject_code_o
);

  // visible flag agrees with the reason code
  a_visible_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (visible_o == (reject_code_o == RC_SEEN)))
    else $error("visible flag and reject code disagree");

  // reason code is a defined one
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (reject_code_o <= RC_ANGLE))
    else $error("reject code out of range");

  // an empty output never stalls the input
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(visible_o)
      && $stable(reject_code_o))
    else $error("stalled result changed");

endmodule

bind camera_frustum_point_visibility cfpv_checker u_cfpv_checker (.*);
